@@ sv/ctru_pkg.sv @@
// Shared constants and widths for the capture tachometer rate unit.
package ctru_pkg;

  localparam int TIMER_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int CAP_W    = 16;
  localparam int CNT_W    = 16;
  localparam int TICK_W   = 32;
  localparam int PERIOD_W = 17;
  localparam int PPR_W    = 8;
  localparam int RATE_W   = 32;

  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ELAP_W   = 32;
  localparam int DEN_W    = ELAP_W + PPR_W;
  localparam int NUM_W    = TICK_W + CNT_W;
  localparam int DVD_W    = NUM_W + FRAC_BITS;
  localparam int HI_W     = DVD_W - RATE_W;
  localparam int SUB_W    = DEN_W + 1;
  localparam int ITER_W   = $clog2(RATE_W);

  localparam logic [CAP_W-1:0] CAP_MASK = (TIMER_BITS >= CAP_W) ? {CAP_W{1'b1}} :
      CAP_W'((64'd1 << TIMER_BITS) - 64'd1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_REV = 2'd2;

  localparam logic [TICK_W-1:0]   TICK_RATE_RST  = 32'd1000000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 17'd65536;
  localparam logic [PPR_W-1:0]    PULSES_REV_RST = 8'd1;

endpackage

@@ sv/capture_tachometer_rate_unit.sv @@
// Top level of the capture tachometer rate unit.
// Each transfer on the input channel yields one rate result in unsigned Q16.16. The unit
// works on one capture at a time: three products on one shared multiplier, a range check,
// then a restoring divider that produces one quotient bit per cycle on a shared
// subtractor. A capture with a zero divisor or a saturated rate skips the divider.
// The next capture is taken while a finished result still waits on the output channel.
// Configuration writes are taken only while the unit is idle.
module capture_tachometer_rate_unit import ctru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CAP_W-1:0]     capture_value,
  input  logic [CNT_W-1:0]     overflow_count,
  input  logic [CNT_W-1:0]     pulse_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RATE_W-1:0]    rev_rate,
  output logic                 saturated,
  output logic                 zero_period,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_OVF = 3'd1;
  localparam logic [2:0] S_ELAPSED = 3'd2;
  localparam logic [2:0] S_MUL_DEN = 3'd3;
  localparam logic [2:0] S_MUL_NUM = 3'd4;
  localparam logic [2:0] S_CHECK   = 3'd5;
  localparam logic [2:0] S_DIV     = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]          state;
  logic [TICK_W-1:0]   tick_rate_hz;
  logic [PERIOD_W-1:0] timer_period;
  logic [PPR_W-1:0]    pulses_per_rev;
  logic [CAP_W-1:0]    last_capture;
  logic [CAP_W-1:0]    cur_cap;
  logic [CNT_W-1:0]    cur_ovf;
  logic [CNT_W-1:0]    cur_pulses;
  logic [ELAP_W-1:0]   elapsed;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;
  logic [RATE_W-1:0]   quo;
  logic [ITER_W-1:0]   iter;
  logic [RATE_W-1:0]   res_rate;
  logic                res_sat;
  logic                res_zero;

  logic                mul_en;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   prod;
  logic [SUB_W-1:0]    sub_a;
  logic [SUB_W-1:0]    diff;
  logic                ge;
  logic [DVD_W-1:0]    dividend;
  logic [HI_W-1:0]     dvd_hi;
  logic                out_load;

  ctru_alu u_alu (
    .clk    (clk),
    .mul_en (mul_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod   (prod),
    .sub_a  (sub_a),
    .sub_b  (den),
    .diff   (diff),
    .ge     (ge)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  assign dividend = DVD_W'(prod[NUM_W-1:0]) << FRAC_BITS;
  assign dvd_hi   = dividend[DVD_W-1:RATE_W];

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_MUL_OVF: begin
        mul_en = 1'b1;
        mul_a  = MUL_A_W'(cur_ovf);
        mul_b  = timer_period;
      end
      S_MUL_DEN: begin
        mul_en = 1'b1;
        mul_a  = elapsed;
        mul_b  = MUL_B_W'(pulses_per_rev);
      end
      S_MUL_NUM: begin
        mul_en = 1'b1;
        mul_a  = tick_rate_hz;
        mul_b  = MUL_B_W'(cur_pulses);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state == S_DIV) begin
      sub_a = {rem, quo[RATE_W-1]};
    end else begin
      sub_a = SUB_W'(dvd_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate_hz   <= TICK_RATE_RST;
      timer_period   <= PERIOD_RST;
      pulses_per_rev <= PULSES_REV_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICK_RATE:  tick_rate_hz   <= cfg_data;
        REG_PERIOD:     timer_period   <= cfg_data[PERIOD_W-1:0];
        REG_PULSES_REV: pulses_per_rev <= cfg_data[PPR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_capture <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL_OVF;
          end
        end
        S_MUL_OVF: state <= S_ELAPSED;
        S_ELAPSED: begin
          last_capture <= cur_cap;
          state        <= S_MUL_DEN;
        end
        S_MUL_DEN: state <= S_MUL_NUM;
        S_MUL_NUM: state <= S_CHECK;
        S_CHECK: begin
          if (den == '0 || ge) begin
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (iter == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_cap    <= capture_value & CAP_MASK;
        cur_ovf    <= overflow_count;
        cur_pulses <= pulse_count;
      end
      S_ELAPSED: begin
        elapsed <= prod[ELAP_W-1:0] + ELAP_W'(cur_cap) - ELAP_W'(last_capture);
      end
      S_MUL_NUM: begin
        den <= prod[DEN_W-1:0];
      end
      S_CHECK: begin
        rem      <= DEN_W'(dvd_hi);
        quo      <= dividend[RATE_W-1:0];
        iter     <= ITER_W'(RATE_W - 1);
        res_zero <= (den == '0);
        res_sat  <= (den != '0) && ge;
        res_rate <= (den == '0) ? '0 : {RATE_W{1'b1}};
      end
      S_DIV: begin
        rem  <= ge ? diff[DEN_W-1:0] : sub_a[DEN_W-1:0];
        quo  <= {quo[RATE_W-2:0], ge};
        iter <= iter - ITER_W'(1);
        if (iter == '0) begin
          res_rate <= {quo[RATE_W-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rev_rate    <= res_rate;
      saturated   <= res_sat;
      zero_period <= res_zero;
    end
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(saturated && zero_period))
    else $error("saturated and zero_period both set");

  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_period |-> rev_rate == '0)
    else $error("zero divisor result with nonzero rate");

  a_sat_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> rev_rate == {RATE_W{1'b1}})
    else $error("saturated result not clamped");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den)
    else $error("partial remainder not below divisor");

  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL_OVF)
    else $error("transfer did not start the sequence");
`endif

endmodule

@@ sv/ctru_alu.sv @@
// Shared arithmetic unit: registered multiplier and wide compare-subtract.
module ctru_alu import ctru_pkg::*; (
  input  logic               clk,
  input  logic               mul_en,
  input  logic [MUL_A_W-1:0] mul_a,
  input  logic [MUL_B_W-1:0] mul_b,
  output logic [PROD_W-1:0]  prod,
  input  logic [SUB_W-1:0]   sub_a,
  input  logic [DEN_W-1:0]   sub_b,
  output logic [SUB_W-1:0]   diff,
  output logic               ge
);

  logic [SUB_W:0] wide_diff;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  assign wide_diff = {1'b0, sub_a} - {2'b00, sub_b};
  assign diff      = wide_diff[SUB_W-1:0];
  assign ge        = ~wide_diff[SUB_W];

endmodule

@@ test/capture_tachometer_rate_unit_test.sv @@
// Regression bench for the capture tachometer rate unit: directed and random captures against a rate predictor.
`timescale 1ns / 1ps

module capture_tachometer_rate_unit_test;
  import ctru_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [63:0] WHOLE_MAX = 64'hFFFF_FFFF >> FRAC_BITS;
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int PHASE_ITEMS   = 82;
  localparam int RANDOM_PHASES = 8;
  localparam int IDLE_PCT      = 27;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int TAIL_CYCLES   = 64;

  typedef struct packed {
    logic [RATE_W-1:0] rev_rate;
    logic              saturated;
    logic              zero_period;
  } rate_result_t;

  class rate_scoreboard;
    logic [TICK_W-1:0]   tick_rate;
    logic [PERIOD_W-1:0] period;
    logic [PPR_W-1:0]    pulses_rev;
    logic [CAP_W-1:0]    last_cap;
    rate_result_t        rates_due[$];
    int                  errors;

    function new();
      tick_rate  = TICK_RATE_RST;
      period     = PERIOD_RST;
      pulses_rev = PULSES_REV_RST;
      last_cap   = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
      case (idx)
        REG_TICK_RATE: begin
          tick_rate = data;
        end
        REG_PERIOD: begin
          period = data[PERIOD_W-1:0];
        end
        REG_PULSES_REV: begin
          pulses_rev = data[PPR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void predict_rate(logic [CAP_W-1:0] cap, logic [CNT_W-1:0] ovf,
                               logic [CNT_W-1:0] pul);
      logic [CAP_W-1:0]  cap_m;
      logic [ELAP_W-1:0] elapsed;
      logic [63:0]       span;
      logic [63:0]       divisor;
      logic [63:0]       numer;
      rate_result_t      r;
      cap_m   = cap & CAP_MASK;
      span    = 64'(ovf) * 64'(period);
      elapsed = ELAP_W'(span) + ELAP_W'(cap_m) - ELAP_W'(last_cap & CAP_MASK);
      divisor = 64'(elapsed) * 64'(pulses_rev);
      r = '0;
      if (divisor == 64'd0) begin
        r.zero_period = 1'b1;
      end else begin
        numer = 64'(tick_rate) * 64'(pul);
        if (numer / divisor > WHOLE_MAX) begin
          r.rev_rate  = '1;
          r.saturated = 1'b1;
        end else begin
          r.rev_rate = RATE_W'((numer << FRAC_BITS) / divisor);
        end
      end
      last_cap = cap_m;
      rates_due.push_back(r);
    endfunction

    function void check_rate(logic [RATE_W-1:0] rate, logic sat, logic zero);
      rate_result_t want;
      if (rates_due.size() == 0) begin
        $display("%0t: unexpected result: rev_rate %h saturated %b zero_period %b",
                 $time, rate, sat, zero);
        errors++;
        return;
      end
      want = rates_due.pop_front();
      if (rate !== want.rev_rate) begin
        $display("%0t: rev_rate expected %h actual %h", $time, want.rev_rate, rate);
        errors++;
      end
      if (sat !== want.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, want.saturated, sat);
        errors++;
      end
      if (zero !== want.zero_period) begin
        $display("%0t: zero_period expected %b actual %b", $time, want.zero_period, zero);
        errors++;
      end
    endfunction

    function int pending();
      return rates_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CAP_W-1:0]     capture_value = '0;
  logic [CNT_W-1:0]     overflow_count = '0;
  logic [CNT_W-1:0]     pulse_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RATE_W-1:0]    rev_rate;
  logic                 saturated;
  logic                 zero_period;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data = '0;

  logic             steady = 1'b0;
  logic             held = 1'b0;
  int               hold_left = 0;
  int               results_seen = 0;
  int               cycles = 0;
  logic [CAP_W-1:0] prev_cap = '0;
  rate_scoreboard   sb;

  capture_tachometer_rate_unit i_dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("capture_tachometer_rate_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_rate(rev_rate, saturated, zero_period);
      if (in_valid && in_ready) sb.predict_rate(capture_value, overflow_count, pulse_count);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        held      <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_capture(input logic [CAP_W-1:0] cap, input logic [CNT_W-1:0] ovf,
                              input logic [CNT_W-1:0] pul);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    capture_value  <= cap;
    overflow_count <= ovf;
    pulse_count    <= pul;
    prev_cap = cap;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_random();
    logic [CAP_W-1:0] cap;
    logic [CNT_W-1:0] ovf;
    logic [CNT_W-1:0] pul;
    cap = CAP_W'($urandom());
    ovf = CNT_W'($urandom());
    pul = CNT_W'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        ovf = CNT_W'($urandom_range(0, 2));
        pul = CNT_W'($urandom_range(1, 64));
      end
      4: begin
        cap = prev_cap;
        ovf = '0;
      end
      5: begin
        cap = prev_cap + CAP_W'($urandom_range(1, 255));
        ovf = '0;
        pul = CNT_W'($urandom_range(0, 8));
      end
      6: begin
        ovf = $urandom_range(0, 1) ? '0 : '1;
        pul = $urandom_range(0, 1) ? '0 : '1;
      end
      default: begin
      end
    endcase
    push_capture(cap, ovf, pul);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_rates(input logic [TICK_W-1:0] tick, input logic [PERIOD_W-1:0] period,
                           input logic [PPR_W-1:0] ppr);
    logic [TICK_W-1:0] word;
    wait_drained();
    write_cfg(REG_TICK_RATE, tick);
    word = $urandom();
    word[PERIOD_W-1:0] = period;
    write_cfg(REG_PERIOD, word);
    word = $urandom();
    word[PPR_W-1:0] = ppr;
    write_cfg(REG_PULSES_REV, word);
    write_cfg(REG_SPARE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TICK_W-1:0]   tick;
    logic [PERIOD_W-1:0] period;
    logic [PPR_W-1:0]    ppr;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_capture(16'h0000, 16'h0000, 16'h0005);
    push_capture(16'hFFFF, 16'h0000, 16'hFFFF);
    push_capture(16'hFFFF, 16'hFFFF, 16'h0001);
    push_capture(16'h0001, 16'h0000, 16'h0001);
    push_capture(16'h0000, 16'h0001, 16'h0000);
    push_capture(16'h8000, 16'h0003, 16'h0064);
    push_capture(16'h8000, 16'h0000, 16'h0001);
    push_capture(16'h0000, 16'hFFFF, 16'hFFFF);

    set_rates(32'd1, 17'd1, 8'd1);
    push_capture(16'h0000, 16'hFFFF, 16'hFFFF);
    push_capture(16'h0001, 16'h0000, 16'h0001);
    push_capture(16'h0000, 16'h0000, 16'hFFFF);
    push_capture(16'hFFFF, 16'h0000, 16'h0001);

    set_rates(32'd0, 17'd0, 8'd1);
    push_capture(16'hFFFF, 16'hFFFF, 16'h0003);
    push_capture(16'h1234, 16'h0007, 16'hFFFF);

    set_rates(32'd5_000_000, 17'd1000, 8'd0);
    push_capture(16'h0010, 16'h0001, 16'h0001);
    push_capture(16'hFFFF, 16'hFFFF, 16'hFFFF);

    set_rates(32'hFFFF_FFFF, 17'd65536, 8'd255);
    push_capture(16'h0000, 16'h0000, 16'hFFFF);
    push_capture(16'h0001, 16'h0000, 16'hFFFF);
    push_capture(16'h0001, 16'hFFFF, 16'h0001);
    push_capture(16'h0001, 16'h0000, 16'h0000);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        set_rates(TICK_RATE_RST, PERIOD_RST, PULSES_REV_RST);
      end else begin
        tick   = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1000, 20_000_000);
        period = ($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom())
                                             : PERIOD_W'($urandom_range(1, 65536));
        ppr    = PPR_W'($urandom_range(1, 255));
        set_rates(tick, period, ppr);
      end
      steady <= (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) push_random();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("capture_tachometer_rate_unit regression: pass");
    else $display("capture_tachometer_rate_unit regression: fail");
    $finish;
  end

endmodule
